### src/jihc_pkg.sv
// shared types, codes and helpers for the joint index homing controller
package jihc_pkg;

  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned DataW = 32;

  localparam logic [1:0] FUNC_TICK  = 2'd0;
  localparam logic [1:0] FUNC_START = 2'd1;
  localparam logic [1:0] FUNC_HOME  = 2'd2;

  localparam logic [1:0] ST_NOT_INIT  = 2'd0;
  localparam logic [1:0] ST_RUNNING   = 2'd1;
  localparam logic [1:0] ST_SUCCEEDED = 2'd2;
  localparam logic [1:0] ST_FAILED    = 2'd3;

  localparam logic [CfgIdxW-1:0] REG_POLARITY = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_INV_GEAR = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_TPC      = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_CPT      = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_MAX_CUR  = 3'd4;
  localparam logic [CfgIdxW-1:0] REG_GAIN_P   = 3'd5;
  localparam logic [CfgIdxW-1:0] REG_GAIN_D   = 3'd6;

  localparam logic [31:0] NINE_TENTHS_Q16 = 32'd58982;
  localparam logic [31:0] ONE_Q16 = 32'h0001_0000;

  typedef struct packed {
    logic [1:0]         func;
    logic signed [31:0] motor_position;
    logic signed [31:0] motor_velocity;
    logic signed [31:0] index_position;
    logic signed [31:0] index_time;
    logic signed [31:0] search_limit;
    logic signed [31:0] step_size;
    logic signed [31:0] home_offset;
  } in_item_t;

  typedef struct packed {
    logic [1:0]         status;
    logic signed [31:0] joint_torque;
    logic signed [31:0] current_target;
    logic               send_now;
    logic signed [31:0] zero_angle_out;
    logic signed [31:0] travelled;
    logic               travelled_valid;
  } out_item_t;

  function automatic logic signed [31:0] sat32(input logic signed [63:0] x);
    logic signed [63:0] hi;
    logic signed [63:0] lo;
    hi = 64'sh0000_0000_7FFF_FFFF;
    lo = -64'sh0000_0000_8000_0000;
    if (x > hi) return 32'sh7FFF_FFFF;
    if (x < lo) return 32'sh8000_0000;
    return x[31:0];
  endfunction

  function automatic logic signed [32:0] pol33(input logic neg, input logic signed [31:0] x);
    logic signed [32:0] w;
    w = 33'(x);
    return neg ? -w : w;
  endfunction

endpackage

### src/joint_index_homing_controller.sv
// top level: homing sequencer around one shared multiplier and a serial divider
// path from acceptance to result valid: a tick before homing, a failed tick or an unused code
// goes straight to S_DONE; start and home pass P0 and P1; a succeeded tick passes P0 to P8; a
// running tick runs the serial budget division and a check, then ends if out of steps, else
// passes P0 to P8, plus P9 and P10 on an index hit; a stalled result adds its stall
// throughput: one item at a time, the next item is taken the cycle after its result is loaded
// reset: synchronous active-low rst_n clears status, zero angle, search state and
// configuration to their defaults
module joint_index_homing_controller #(
  parameter int unsigned CFG_IDX_W = jihc_pkg::CfgIdxW
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  jihc_pkg::in_item_t   in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output jihc_pkg::out_item_t  out_data,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]          cfg_data
);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_DIV  = 4'd1;
  localparam logic [3:0] S_CHK  = 4'd2;
  localparam logic [3:0] S_P0   = 4'd3;
  localparam logic [3:0] S_P1   = 4'd4;
  localparam logic [3:0] S_P2   = 4'd5;
  localparam logic [3:0] S_P3   = 4'd6;
  localparam logic [3:0] S_P4   = 4'd7;
  localparam logic [3:0] S_P5   = 4'd8;
  localparam logic [3:0] S_P6   = 4'd9;
  localparam logic [3:0] S_P7   = 4'd10;
  localparam logic [3:0] S_P8   = 4'd11;
  localparam logic [3:0] S_P9   = 4'd12;
  localparam logic [3:0] S_P10  = 4'd13;
  localparam logic [3:0] S_DONE = 4'd14;

  // configuration
  logic        pol_r;
  logic [31:0] igr_r, tpc_r, cpt_r;
  logic [30:0] maxc_r, gp_r, gd_r;

  // homing state
  logic [1:0]         stat_r;
  logic signed [31:0] zero_r, target_r, last_it_r, start_r, end_r;
  logic signed [31:0] limit_r, step_r, off_r;
  logic [31:0]        step_cnt_r;

  // sequencer
  logic [3:0]          state_r, state_nxt;
  jihc_pkg::in_item_t  item_r;
  logic signed [31:0]  diff_r, vel_r, torque_r, cur_r;
  logic signed [49:0]  t1_r;
  logic signed [50:0]  t_r;
  logic                send_r;
  logic [31:0]         rem_r, quo_r, dvs_r;
  logic [4:0]          div_cnt_r;
  logic                out_valid_r;
  jihc_pkg::out_item_t out_r;

  // shared multiplier
  logic signed [32:0] op_a;
  logic [31:0]        op_b, mag;
  logic [63:0]        prod_r;
  logic               neg_r;
  logic [64:0]        rnd;
  logic signed [49:0] mres;

  logic signed [31:0] zero_use, ang, diff_c, mt, lim, torque_c, cur_c, c32, ia, zero_new;
  logic signed [50:0] lim51;
  logic signed [49:0] mc50;
  logic [32:0]        rem_sh;
  logic [31:0]        al, as_abs, budget;
  logic               idx_hit;

  assign in_ready  = (state_r == S_IDLE);
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  always_comb begin
    op_a = jihc_pkg::pol33(pol_r, item_r.motor_position);
    op_b = igr_r;
    case (state_r)
      S_P1: begin
        op_a = jihc_pkg::pol33(pol_r, item_r.motor_velocity);
      end
      S_P2: begin
        op_a = 33'(diff_r);
        op_b = {1'b0, gp_r};
      end
      S_P3: begin
        op_a = 33'(vel_r);
        op_b = {1'b0, gd_r};
      end
      S_P4: begin
        op_a = $signed({2'b00, maxc_r});
        op_b = tpc_r;
      end
      S_P5: begin
        op_a = $signed({1'b0, mt});
        op_b = jihc_pkg::NINE_TENTHS_Q16;
      end
      S_P7: begin
        op_a = 33'(torque_r);
        op_b = cpt_r;
      end
      S_P9: begin
        op_a = jihc_pkg::pol33(pol_r, item_r.index_position);
      end
      default: begin
      end
    endcase
  end

  assign mag  = op_a[32] ? 32'((-op_a)) : op_a[31:0];
  assign rnd  = {1'b0, prod_r} + 65'h0_0000_0000_0000_FFFF;
  assign mres = neg_r ? -$signed({1'b0, rnd[64:16]}) : $signed({2'b00, prod_r[63:16]});

  always_ff @(posedge clk) begin
    prod_r <= mag * op_b;
    neg_r  <= op_a[32];
  end

  // datapath around the multiplier result
  assign zero_use = (item_r.func == jihc_pkg::FUNC_TICK) ? zero_r : 32'sd0;
  assign ang      = jihc_pkg::sat32(64'(jihc_pkg::sat32(64'(mres))) - 64'(zero_use));
  assign diff_c   = jihc_pkg::sat32(64'(target_r) - 64'(ang));
  assign mt       = (mres > 50'sh0_0000_7FFF_FFFF) ? 32'sh7FFF_FFFF : mres[31:0];
  assign lim      = mres[31:0];
  assign lim51    = $signed({19'b0, lim});
  assign torque_c = (t_r > lim51) ? lim : ((t_r < -lim51) ? -lim : t_r[31:0]);
  assign mc50     = $signed({19'b0, maxc_r});
  assign c32      = (mres > mc50) ? mres[31:0] & 32'h0 | {1'b0, maxc_r}
                  : ((mres < -mc50) ? -$signed({1'b0, maxc_r}) : mres[31:0]);
  assign cur_c    = pol_r ? -c32 : c32;
  assign ia       = jihc_pkg::sat32(64'(mres));
  assign zero_new = jihc_pkg::sat32(64'(ia) + 64'(off_r));
  assign idx_hit  = (item_r.func == jihc_pkg::FUNC_TICK) && (stat_r == jihc_pkg::ST_RUNNING)
                  && (item_r.index_time > last_it_r);

  assign rem_sh = {rem_r, quo_r[31]};
  assign al     = limit_r[31] ? 32'(-limit_r) : limit_r;
  assign as_abs = step_r[31] ? 32'(-step_r) : step_r;
  assign budget = (dvs_r == 32'd0) ? 32'd0 : quo_r;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          case (in_data.func)
            jihc_pkg::FUNC_START, jihc_pkg::FUNC_HOME: state_nxt = S_P0;
            jihc_pkg::FUNC_TICK: begin
              if (stat_r == jihc_pkg::ST_RUNNING) state_nxt = S_DIV;
              else if (stat_r == jihc_pkg::ST_SUCCEEDED) state_nxt = S_P0;
              else state_nxt = S_DONE;
            end
            default: state_nxt = S_DONE;
          endcase
        end
      end
      S_DIV: if (div_cnt_r == 5'd31) state_nxt = S_CHK;
      S_CHK: state_nxt = (step_cnt_r >= budget) ? S_DONE : S_P0;
      S_P0: state_nxt = S_P1;
      S_P1: state_nxt = (item_r.func == jihc_pkg::FUNC_TICK) ? S_P2 : S_DONE;
      S_P2: state_nxt = S_P3;
      S_P3: state_nxt = S_P4;
      S_P4: state_nxt = S_P5;
      S_P5: state_nxt = S_P6;
      S_P6: state_nxt = S_P7;
      S_P7: state_nxt = S_P8;
      S_P8: state_nxt = idx_hit ? S_P9 : S_DONE;
      S_P9: state_nxt = S_P10;
      S_P10: state_nxt = S_DONE;
      S_DONE: if (!out_valid_r || out_ready) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      pol_r       <= 1'b0;
      igr_r       <= jihc_pkg::ONE_Q16;
      tpc_r       <= jihc_pkg::ONE_Q16;
      cpt_r       <= jihc_pkg::ONE_Q16;
      maxc_r      <= '0;
      gp_r        <= '0;
      gd_r        <= '0;
      stat_r      <= jihc_pkg::ST_NOT_INIT;
      zero_r      <= '0;
      target_r    <= '0;
      step_cnt_r  <= '0;
      last_it_r   <= -32'sd1;
      start_r     <= '0;
      end_r       <= '0;
      limit_r     <= '0;
      step_r      <= '0;
      off_r       <= '0;
    end else begin
      state_r <= state_nxt;
      if ((state_r == S_DONE) && (!out_valid_r || out_ready)) out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;

      if (cfg_valid) begin
        case (cfg_index)
          jihc_pkg::REG_POLARITY: pol_r  <= cfg_data[0];
          jihc_pkg::REG_INV_GEAR: igr_r  <= cfg_data;
          jihc_pkg::REG_TPC:      tpc_r  <= cfg_data;
          jihc_pkg::REG_CPT:      cpt_r  <= cfg_data;
          jihc_pkg::REG_MAX_CUR:  maxc_r <= cfg_data[30:0];
          jihc_pkg::REG_GAIN_P:   gp_r   <= cfg_data[30:0];
          jihc_pkg::REG_GAIN_D:   gd_r   <= cfg_data[30:0];
          default: begin
          end
        endcase
      end

      case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            item_r    <= in_data;
            torque_r  <= '0;
            cur_r     <= '0;
            send_r    <= (in_data.func == jihc_pkg::FUNC_TICK)
                         && (stat_r == jihc_pkg::ST_NOT_INIT);
            rem_r     <= '0;
            quo_r     <= al;
            dvs_r     <= as_abs;
            div_cnt_r <= '0;
          end
        end
        S_DIV: begin
          div_cnt_r <= div_cnt_r + 5'd1;
          if (rem_sh >= {1'b0, dvs_r}) begin
            rem_r <= 32'(rem_sh - {1'b0, dvs_r});
            quo_r <= {quo_r[30:0], 1'b1};
          end else begin
            rem_r <= rem_sh[31:0];
            quo_r <= {quo_r[30:0], 1'b0};
          end
        end
        S_CHK: begin
          if (step_cnt_r >= budget) begin
            stat_r <= jihc_pkg::ST_FAILED;
          end else begin
            step_cnt_r <= step_cnt_r + 32'd1;
            target_r   <= jihc_pkg::sat32(64'(target_r) + 64'(step_r));
          end
        end
        S_P1: begin
          diff_r <= diff_c;
          if (item_r.func == jihc_pkg::FUNC_START) begin
            zero_r     <= '0;
            limit_r    <= item_r.search_limit;
            step_r     <= item_r.step_size;
            off_r      <= item_r.home_offset;
            last_it_r  <= item_r.index_time;
            target_r   <= ang;
            start_r    <= ang;
            step_cnt_r <= '0;
            stat_r     <= jihc_pkg::ST_RUNNING;
          end else if (item_r.func == jihc_pkg::FUNC_HOME) begin
            off_r  <= item_r.home_offset;
            zero_r <= jihc_pkg::sat32(64'(ang) + 64'(item_r.home_offset));
            stat_r <= jihc_pkg::ST_SUCCEEDED;
          end
        end
        S_P2: vel_r <= jihc_pkg::sat32(64'(mres));
        S_P3: t1_r <= mres;
        S_P4: t_r <= 51'(t1_r) - 51'(mres);
        S_P6: torque_r <= torque_c;
        S_P8: cur_r <= cur_c;
        S_P10: begin
          end_r    <= ia;
          zero_r   <= zero_new;
          target_r <= jihc_pkg::sat32(64'(target_r) - 64'(zero_new));
          stat_r   <= jihc_pkg::ST_SUCCEEDED;
        end
        S_DONE: begin
          if (!out_valid_r || out_ready) begin
            out_r.status         <= stat_r;
            out_r.joint_torque   <= torque_r;
            out_r.current_target <= cur_r;
            out_r.send_now       <= send_r;
            out_r.zero_angle_out <= zero_r;
            if (stat_r == jihc_pkg::ST_SUCCEEDED) begin
              out_r.travelled       <= jihc_pkg::sat32(64'(end_r) - 64'(start_r));
              out_r.travelled_valid <= 1'b1;
            end else begin
              out_r.travelled       <= '0;
              out_r.travelled_valid <= 1'b0;
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

endmodule

### src/jihc_checker.sv
// port-level checker for the joint index homing controller, with its bind
module jihc_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_ready,
  input logic                out_valid,
  input logic                out_ready,
  input jihc_pkg::out_item_t out_data
);

  // a stalled item holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("output item changed while stalled");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid after reset");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input ready right after an accepted item");

  a_trav_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.travelled_valid == (out_data.status == jihc_pkg::ST_SUCCEEDED))
    else $error("travelled valid disagrees with status");

  a_send_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.send_now |->
      out_data.joint_torque == 32'sd0 && out_data.status == jihc_pkg::ST_NOT_INIT)
    else $error("send now with torque or wrong status");

endmodule

bind joint_index_homing_controller jihc_checker u_jihc_checker (
  .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
  .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
);
